[rtl/core/silence_trim_peak_normalize_macros.svh]
// Assertion macros for the silence trim block.
// Used by the top level; relies on clk_i and rst_ni in scope.
`ifndef SILENCE_TRIM_PEAK_NORMALIZE_MACROS_SVH
`define SILENCE_TRIM_PEAK_NORMALIZE_MACROS_SVH

// clocked check, disabled in reset
`define STPN_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("stpn check failed");

// clocked check with a caller message
`define STPN_CHECK_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

[rtl/core/stpn_pkg.sv]
// Shared types and constants for the silence trim / peak normalize block.
// No dependencies.
package stpn_pkg;

  typedef enum logic [1:0] {
    REG_CHANNELS  = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_TARGET    = 2'd2,
    REG_MAXFRAMES = 2'd3
  } reg_idx_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_BOUND  = 6'b000100,
    ST_PEAK   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_RDWAIT = 6'b100000
  } back_state_e;

  localparam logic        OP_LOAD = 1'b0;
  localparam logic        OP_READ = 1'b1;

  localparam logic [3:0]  RST_CHANNELS  = 4'd2;
  localparam logic [14:0] RST_THRESHOLD = 15'd655;
  localparam logic [14:0] RST_TARGET    = 15'd32440;
  localparam logic [16:0] RST_MAXFRAMES = 17'd48000;
  localparam logic [15:0] UNITY_SCALE   = 16'd32768;
  localparam int          DIV_STEPS     = 30;

  typedef struct packed {
    logic               is_read;
    logic signed [15:0] sample;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_stat_t;

endpackage

[rtl/core/stpn_front.sv]
// Front end: accepts beats, classifies load/read, queues them for the back end.
// Depends on stpn_pkg.
module stpn_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic signed [15:0]   sample_in_i,
  input  logic                 last_in_i,
  output stpn_pkg::q_stat_t    q_stat_o,
  input  logic                 pop_i
);

  stpn_pkg::cmd_t fifo_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 3'd4);
  assign push = in_valid_i && in_ready_o;
  assign pop  = pop_i && (cnt_q != 3'd0);

  assign q_stat_o.valid = (cnt_q != 3'd0);
  assign q_stat_o.cmd   = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 2'd1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 2'd1 : rd_ptr_q;
    cnt_d    = cnt_q + {2'b00, push} - {2'b00, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].is_read <= (operation_i == stpn_pkg::OP_READ);
      fifo_q[wr_ptr_q].sample  <= sample_in_i;
      fifo_q[wr_ptr_q].last    <= last_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/core/stpn_back.sv]
// Back end: sample store, end-of-recording scans, scale divider, read-out.
// Depends on stpn_pkg; fed by stpn_front.
module stpn_back #(
  parameter int STORE_SAMPLES = 65536,
  parameter int MAX_CHANNELS  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stpn_pkg::q_stat_t    q_stat_i,
  output logic                 pop_o,
  input  logic [3:0]           channel_count_i,
  input  logic [14:0]          silence_threshold_i,
  input  logic [14:0]          target_peak_i,
  input  logic [16:0]          max_frames_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [15:0]   sample_out_o,
  output logic                 clip_end_o,
  output logic                 no_sound_o
);

  localparam int AW  = $clog2(STORE_SAMPLES);
  localparam int CHW = $clog2(MAX_CHANNELS + 1);
  localparam int CW  = (AW + 1 > 17) ? AW + 1 : 17;
  localparam logic [4:0]  MAXC  = 5'(MAX_CHANNELS);
  localparam logic [AW:0] DEPTH = (AW + 1)'(STORE_SAMPLES);

  logic [15:0] mem [STORE_SAMPLES];
  logic [15:0] rdata_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata;

  stpn_pkg::back_state_e st_q, st_d;
  logic [AW:0]  wcount_q, wcount_d, rd_idx_q, rd_idx_d;
  logic [AW:0]  clip_first_q, clip_first_d, clip_len_q, clip_len_d;
  logic [15:0]  scale_q, scale_d;
  logic         done_q, done_d;
  logic [CHW-1:0] ch_q, ch_d, c_q, c_d;
  logic [14:0]  thr_q, thr_d, tgt_q, tgt_d, peak_q, peak_d;
  logic [16:0]  cap_q, cap_d;
  logic [AW:0]  addr_q, addr_d, f_q, f_d, n_q, n_d;
  logic [AW:0]  first_q, first_d, lastf_q, lastf_d, tfr_q, tfr_d;
  logic         issue_done_q, issue_done_d, tv_q, tv_d, tf_q, tf_d;
  logic         acc_q, acc_d, seen_q, seen_d, rlast_q, rlast_d;
  logic [15:0]  rem_q, rem_d;
  logic [29:0]  num_q, num_d;
  logic [4:0]   dcnt_q, dcnt_d;
  logic         ov_q, ov_d, oend_q, oend_d, ons_q, ons_d;
  logic signed [15:0] osmp_q, osmp_d;

  logic [4:0]   ch5, eff5;
  logic [AW:0]  wbase, diff, cframes;
  logic [CW-1:0] capx;
  logic [15:0]  mag;
  logic [16:0]  rmag, rsub;
  logic [32:0]  prod;
  logic [16:0]  smag;
  logic         loud_now;

  assign pop_o        = (st_q == stpn_pkg::ST_IDLE) && q_stat_i.valid &&
                        (!q_stat_i.cmd.is_read || !ov_q);
  assign out_valid_o  = ov_q;
  assign sample_out_o = osmp_q;
  assign clip_end_o   = oend_q;
  assign no_sound_o   = ons_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    st_d = st_q; wcount_d = wcount_q; rd_idx_d = rd_idx_q;
    clip_first_d = clip_first_q; clip_len_d = clip_len_q; scale_d = scale_q;
    done_d = done_q; ch_d = ch_q; c_d = c_q; thr_d = thr_q; tgt_d = tgt_q;
    peak_d = peak_q; cap_d = cap_q; addr_d = addr_q; f_d = f_q; n_d = n_q;
    first_d = first_q; lastf_d = lastf_q; tfr_d = tfr_q;
    issue_done_d = issue_done_q; tv_d = 1'b0; tf_d = tf_q; acc_d = acc_q;
    seen_d = seen_q; rlast_d = rlast_q; rem_d = rem_q; num_d = num_q;
    dcnt_d = dcnt_q; ov_d = ov_q && !out_ready_i; oend_d = oend_q;
    ons_d = ons_q; osmp_d = osmp_q;
    mem_we = 1'b0; mem_re = 1'b0; mem_waddr = '0; mem_raddr = '0;
    mem_wdata = q_stat_i.cmd.sample;
    wbase = done_q ? '0 : wcount_q;
    ch5  = {1'b0, channel_count_i};
    eff5 = (ch5 == 5'd0) ? 5'd1 : ((ch5 > MAXC) ? MAXC : ch5);
    diff = lastf_q + (AW + 1)'(1) - first_q;
    capx = CW'(cap_q);
    cframes = ({{(CW - AW - 1){1'b0}}, diff} > capx) ? (AW + 1)'(cap_q) : diff;
    mag  = rdata_q[15] ? 16'(-rdata_q) : rdata_q;
    loud_now = (mag > {1'b0, thr_q});
    rmag = {rem_q, num_q[29]};
    rsub = rmag - {1'b0, 1'b0, rem_q[14:0] & 15'd0} - {1'b0, 1'b0, peak_q};
    smag = rdata_q[15] ? 17'(-{rdata_q[15], rdata_q}) : {1'b0, rdata_q};
    prod = {16'd0, smag} * {17'd0, scale_q};

    case (st_q)
      stpn_pkg::ST_IDLE: begin
        if (pop_o && !q_stat_i.cmd.is_read) begin
          if (done_q) begin
            rd_idx_d = '0;
            done_d   = 1'b0;
          end
          wcount_d = wbase;
          if (wbase < DEPTH) begin
            mem_we    = 1'b1;
            mem_waddr = wbase[AW-1:0];
            wcount_d  = wbase + (AW + 1)'(1);
          end
          if (q_stat_i.cmd.last) begin
            ch_d  = CHW'(eff5);
            thr_d = silence_threshold_i;
            tgt_d = target_peak_i;
            cap_d = (max_frames_i == 17'd0) ? 17'd1 : max_frames_i;
            addr_d = '0; c_d = '0; f_d = '0; issue_done_d = 1'b0;
            acc_d = 1'b0; seen_d = 1'b0; first_d = '0; lastf_d = '0;
            st_d = stpn_pkg::ST_SCAN;
          end
        end else if (pop_o) begin
          if (!done_q || clip_len_q == '0) begin
            ov_d = 1'b1; osmp_d = '0; oend_d = 1'b0; ons_d = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(clip_first_q + rd_idx_q);
            rlast_d   = (rd_idx_q + (AW + 1)'(1) == clip_len_q);
            rd_idx_d  = rlast_d ? '0 : rd_idx_q + (AW + 1)'(1);
            st_d      = stpn_pkg::ST_RDWAIT;
          end
        end
      end
      stpn_pkg::ST_SCAN: begin
        if (!issue_done_q) begin
          if (c_q == '0 &&
              ({1'b0, addr_q} + (AW + 2)'(ch_q) > {1'b0, wcount_q})) begin
            issue_done_d = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = addr_q[AW-1:0];
            tv_d      = 1'b1;
            tf_d      = (CHW'(c_q + 1'b1) == ch_q);
            tfr_d     = f_q;
            addr_d    = addr_q + (AW + 1)'(1);
            if (CHW'(c_q + 1'b1) == ch_q) begin
              c_d = '0;
              f_d = f_q + (AW + 1)'(1);
            end else begin
              c_d = CHW'(c_q + 1'b1);
            end
          end
        end
        if (tv_q) begin
          if (tf_q) begin
            acc_d = 1'b0;
            if (acc_q || loud_now) begin
              if (!seen_q) begin
                first_d = tfr_q;
              end
              lastf_d = tfr_q;
              seen_d  = 1'b1;
            end
          end else begin
            acc_d = acc_q || loud_now;
          end
        end
        if (issue_done_q && !tv_q) begin
          st_d = stpn_pkg::ST_BOUND;
        end
      end
      stpn_pkg::ST_BOUND: begin
        peak_d = '0;
        if (!seen_q) begin
          clip_len_d = '0; scale_d = stpn_pkg::UNITY_SCALE;
          rd_idx_d = '0; done_d = 1'b1; st_d = stpn_pkg::ST_IDLE;
        end else begin
          clip_first_d = (AW + 1)'(first_q * ch_q);
          clip_len_d   = (AW + 1)'(cframes * ch_q);
          addr_d       = (AW + 1)'(first_q * ch_q);
          n_d          = (AW + 1)'(cframes * ch_q);
          st_d         = stpn_pkg::ST_PEAK;
        end
      end
      stpn_pkg::ST_PEAK: begin
        if (n_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = addr_q[AW-1:0];
          tv_d      = 1'b1;
          addr_d    = addr_q + (AW + 1)'(1);
          n_d       = n_q - (AW + 1)'(1);
        end
        if (tv_q && !rdata_q[15] && (rdata_q[14:0] > peak_q)) begin
          peak_d = rdata_q[14:0];
        end
        if (n_q == '0 && !tv_q) begin
          if (peak_q > tgt_q) begin
            rem_d = '0; num_d = {tgt_q, 15'd0};
            dcnt_d = 5'(stpn_pkg::DIV_STEPS);
            st_d = stpn_pkg::ST_DIV;
          end else begin
            scale_d = stpn_pkg::UNITY_SCALE; rd_idx_d = '0;
            done_d = 1'b1; st_d = stpn_pkg::ST_IDLE;
          end
        end
      end
      stpn_pkg::ST_DIV: begin
        if (rmag >= {2'b00, peak_q}) begin
          rem_d = rsub[15:0];
          num_d = {num_q[28:0], 1'b1};
        end else begin
          rem_d = rmag[15:0];
          num_d = {num_q[28:0], 1'b0};
        end
        dcnt_d = dcnt_q - 5'd1;
        if (dcnt_q == 5'd1) begin
          scale_d = num_d[15:0]; rd_idx_d = '0;
          done_d = 1'b1; st_d = stpn_pkg::ST_IDLE;
        end
      end
      stpn_pkg::ST_RDWAIT: begin
        ov_d   = 1'b1;
        oend_d = rlast_q;
        ons_d  = 1'b0;
        osmp_d = rdata_q[15] ? 16'(-prod[31:15]) : prod[30:15];
        st_d   = stpn_pkg::ST_IDLE;
      end
      default: begin
        st_d = stpn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= stpn_pkg::ST_IDLE; wcount_q <= '0; rd_idx_q <= '0;
      clip_first_q <= '0; clip_len_q <= '0; scale_q <= stpn_pkg::UNITY_SCALE;
      done_q <= 1'b0; ch_q <= '0; c_q <= '0; thr_q <= '0; tgt_q <= '0;
      peak_q <= '0; cap_q <= '0; addr_q <= '0; f_q <= '0; n_q <= '0;
      first_q <= '0; lastf_q <= '0; tfr_q <= '0; issue_done_q <= 1'b0;
      tv_q <= 1'b0; tf_q <= 1'b0; acc_q <= 1'b0; seen_q <= 1'b0;
      rlast_q <= 1'b0; rem_q <= '0; num_q <= '0; dcnt_q <= '0;
      ov_q <= 1'b0; oend_q <= 1'b0; ons_q <= 1'b0; osmp_q <= '0;
    end else begin
      st_q <= st_d; wcount_q <= wcount_d; rd_idx_q <= rd_idx_d;
      clip_first_q <= clip_first_d; clip_len_q <= clip_len_d; scale_q <= scale_d;
      done_q <= done_d; ch_q <= ch_d; c_q <= c_d; thr_q <= thr_d; tgt_q <= tgt_d;
      peak_q <= peak_d; cap_q <= cap_d; addr_q <= addr_d; f_q <= f_d; n_q <= n_d;
      first_q <= first_d; lastf_q <= lastf_d; tfr_q <= tfr_d;
      issue_done_q <= issue_done_d; tv_q <= tv_d; tf_q <= tf_d; acc_q <= acc_d;
      seen_q <= seen_d; rlast_q <= rlast_d; rem_q <= rem_d; num_q <= num_d;
      dcnt_q <= dcnt_d; ov_q <= ov_d; oend_q <= oend_d; ons_q <= ons_d;
      osmp_q <= osmp_d;
    end
  end

endmodule

[rtl/core/silence_trim_peak_normalize.sv]
// Silence trim with peak normalize. Load: one beat per cycle while the back end idles.
// Read: the store read is registered, then the scaled sample is registered in the
// output register; a new read pops only while the back end is idle and that register
// is empty. Recording end: one store read port scans twice, then a 30-step divider
// runs if peak > target; no beats are popped meanwhile, and the front queue holds 4.
// Reset clears all control state; the sample store itself is not cleared.
`include "silence_trim_peak_normalize_macros.svh"
module silence_trim_peak_normalize #(
  parameter int STORE_SAMPLES = 65536,
  parameter int MAX_CHANNELS  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic signed [15:0] sample_in_i,
  input  logic               last_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_out_o,
  output logic               clip_end_o,
  output logic               no_sound_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [3:0]  chan_q;
  logic [14:0] thr_q, tgt_q;
  logic [16:0] maxf_q;
  stpn_pkg::q_stat_t q_stat;
  logic pop;
  stpn_pkg::reg_idx_e ridx;
  logic ns_beat_clean;

  assign pready = 1'b1;
  assign ridx   = stpn_pkg::reg_idx_e'(paddr[3:2]);
  assign ns_beat_clean = (sample_out_o == 16'sd0) && !clip_end_o;

  always_comb begin
    case (ridx)
      stpn_pkg::REG_CHANNELS:  prdata = {28'd0, chan_q};
      stpn_pkg::REG_THRESHOLD: prdata = {17'd0, thr_q};
      stpn_pkg::REG_TARGET:    prdata = {17'd0, tgt_q};
      stpn_pkg::REG_MAXFRAMES: prdata = {15'd0, maxf_q};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= stpn_pkg::RST_CHANNELS;
      thr_q  <= stpn_pkg::RST_THRESHOLD;
      tgt_q  <= stpn_pkg::RST_TARGET;
      maxf_q <= stpn_pkg::RST_MAXFRAMES;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        stpn_pkg::REG_CHANNELS:  chan_q <= pwdata[3:0];
        stpn_pkg::REG_THRESHOLD: thr_q  <= pwdata[14:0];
        stpn_pkg::REG_TARGET:    tgt_q  <= pwdata[14:0];
        stpn_pkg::REG_MAXFRAMES: maxf_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  stpn_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .sample_in_i,
    .last_in_i, .q_stat_o(q_stat), .pop_i(pop)
  );

  stpn_back #(
    .STORE_SAMPLES(STORE_SAMPLES), .MAX_CHANNELS(MAX_CHANNELS)
  ) u_back (
    .clk_i, .rst_ni, .q_stat_i(q_stat), .pop_o(pop),
    .channel_count_i(chan_q), .silence_threshold_i(thr_q),
    .target_peak_i(tgt_q), .max_frames_i(maxf_q),
    .out_valid_o, .out_ready_i, .sample_out_o, .clip_end_o, .no_sound_o
  );

  `STPN_CHECK(a_pop_nonempty, pop |-> q_stat.valid)
  `STPN_CHECK_MSG(a_nosound_zero, out_valid_o && no_sound_o |-> ns_beat_clean, "bad no_sound beat")
  `STPN_CHECK(a_read_pop_free, pop && q_stat.cmd.is_read |-> !out_valid_o)

endmodule
